FILE: src/smm_pkg.sv
package smm_pkg;

	localparam int SIZE_W  = 4;
	localparam int IDX_W   = 3;
	localparam int VALUE_W = 32;
	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;

	localparam logic [SIZE_W-1:0] SIZE_RESET = 4'd8;

	// Word index of each configuration register (paddr[2]).
	localparam logic REG_MATRIX_SIZE = 1'b0;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic             wr_en;
		logic             wr_second;
		logic             rd_en;
		logic             first;
		logic             last;
		logic             load_out;
		logic [IDX_W-1:0] out_row;
		logic [IDX_W-1:0] out_col;
		logic             out_last;
	} cmd_t;

	// Status from the datapath back to the controller.
	typedef struct packed {
		logic acc_valid;
		logic out_free;
	} status_t;

endpackage

FILE: src/smm_item_if.sv
interface smm_item_if;
	import smm_pkg::*;

	logic                      valid;
	logic                      ready;
	logic                      compute;
	logic                      load_second;
	logic [IDX_W-1:0]          row_index;
	logic [IDX_W-1:0]          col_index;
	logic signed [VALUE_W-1:0] element_value;

	modport source (
		output valid, compute, load_second, row_index, col_index, element_value,
		input  ready
	);
	modport sink (
		input  valid, compute, load_second, row_index, col_index, element_value,
		output ready
	);
endinterface

FILE: src/smm_result_if.sv
interface smm_result_if;
	import smm_pkg::*;

	logic                      valid;
	logic                      ready;
	logic signed [VALUE_W-1:0] product_value;
	logic [IDX_W-1:0]          out_row;
	logic [IDX_W-1:0]          out_col;
	logic                      last_element;

	modport source (
		output valid, product_value, out_row, out_col, last_element,
		input  ready
	);
	modport sink (
		input  valid, product_value, out_row, out_col, last_element,
		output ready
	);
endinterface

FILE: src/square_matrix_multiply.sv
// Channel   Direction  Contents
// items     in         compute, load_second, row_index, col_index, element_value
// results   out        product_value, out_row, out_col, last_element
// apb       in/out     matrix_size at byte address 0 (paddr[2] selects the word)
//
// A load word is written into its matrix in the cycle it is accepted.
// A compute word runs each product element as n serial multiply-accumulates
// through the single multiplier, followed by the read, multiply and
// accumulate registers before the element is emitted.
// Reset clears the controller, the pipeline tags and the output flag; the
// matrices themselves are not cleared and hold whatever was last loaded.
// A stalled result word stops the next element only when it is ready to leave.
module square_matrix_multiply #(
	parameter int MAX_DIM = 8
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [smm_pkg::PADDR_W-1:0]   paddr,
	input  logic [smm_pkg::PDATA_W-1:0]   pwdata,
	output logic [smm_pkg::PDATA_W-1:0]   prdata,
	output logic                          pready,
	smm_item_if.sink                      items,
	smm_result_if.source                  results
);
	import smm_pkg::*;

	localparam int DEPTH = MAX_DIM * MAX_DIM;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [SIZE_W-1:0] matrix_size_q;
	cmd_t              cmd;
	status_t           status;
	logic [AW-1:0]     wr_addr;
	logic [AW-1:0]     rd_a_addr;
	logic [AW-1:0]     rd_b_addr;

	// The configuration port never stalls. Only the matrix size register
	// exists; the upper word address reads as zero and ignores writes.
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			matrix_size_q <= SIZE_RESET;
		end else if (psel && penable && pwrite && (paddr[2] == REG_MATRIX_SIZE)) begin
			matrix_size_q <= pwdata[SIZE_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr[2] == REG_MATRIX_SIZE) begin
			prdata = PDATA_W'(matrix_size_q);
		end
	end

	// The controller walks rows, columns and the inner index; the datapath
	// holds both matrices, the multiply-accumulate pipeline and the output
	// register that lets the next element proceed while one waits.
	smm_ctrl #(.MAX_DIM(MAX_DIM)) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.matrix_size  (matrix_size_q),
		.item_valid   (items.valid),
		.item_compute (items.compute),
		.item_row     (items.row_index),
		.item_col     (items.col_index),
		.item_second  (items.load_second),
		.item_ready   (items.ready),
		.status       (status),
		.cmd          (cmd),
		.wr_addr      (wr_addr),
		.rd_a_addr    (rd_a_addr),
		.rd_b_addr    (rd_b_addr)
	);

	smm_datapath #(.MAX_DIM(MAX_DIM)) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.wr_addr   (wr_addr),
		.rd_a_addr (rd_a_addr),
		.rd_b_addr (rd_b_addr),
		.wr_data   (items.element_value),
		.status    (status),
		.results   (results)
	);

	// A compute word makes the block busy on the very next cycle.
	a_busy_after_compute: assert property (@(posedge clk) disable iff (!arst_n)
		(items.valid && items.ready && items.compute) |=> !items.ready)
		else $error("block took a word straight after a compute word");

	// Matrix reads are issued only while a compute word is in progress.
	a_reads_when_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rd_en |-> !items.ready)
		else $error("matrix read issued while idle");

	// The output register is only loaded when it is empty or being emptied.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> (status.out_free && status.acc_valid))
		else $error("result word overwritten before it was taken");

	// The final element sits on the diagonal.
	a_last_on_diagonal: assert property (@(posedge clk) disable iff (!arst_n)
		(results.valid && results.last_element) |-> (results.out_row == results.out_col))
		else $error("last element is off the diagonal");

endmodule

FILE: src/smm_ram.sv
module smm_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                                        clk,
	input  logic                                        wr_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  logic [WIDTH-1:0]                            wr_data,
	input  logic                                        rd_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic [WIDTH-1:0]                            rd_data
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end
endmodule

FILE: src/smm_ctrl.sv
module smm_ctrl #(
	parameter int MAX_DIM = 8
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [smm_pkg::SIZE_W-1:0]    matrix_size,
	input  logic                          item_valid,
	input  logic                          item_compute,
	input  logic [smm_pkg::IDX_W-1:0]     item_row,
	input  logic [smm_pkg::IDX_W-1:0]     item_col,
	input  logic                          item_second,
	output logic                          item_ready,
	input  smm_pkg::status_t              status,
	output smm_pkg::cmd_t                 cmd,
	output logic [((MAX_DIM * MAX_DIM > 1) ? $clog2(MAX_DIM * MAX_DIM) : 1)-1:0] wr_addr,
	output logic [((MAX_DIM * MAX_DIM > 1) ? $clog2(MAX_DIM * MAX_DIM) : 1)-1:0] rd_a_addr,
	output logic [((MAX_DIM * MAX_DIM > 1) ? $clog2(MAX_DIM * MAX_DIM) : 1)-1:0] rd_b_addr
);
	import smm_pkg::*;

	localparam int DEPTH = MAX_DIM * MAX_DIM;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW    = $clog2(MAX_DIM + 1);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_ISSUE = 2'd1;
	localparam logic [1:0] ST_WAIT  = 2'd2;

	logic [1:0]    state_q;
	logic [CW-1:0] r_q;
	logic [CW-1:0] c_q;
	logic [CW-1:0] i_q;
	logic [CW-1:0] n_eff;
	logic [CW-1:0] n_m1;
	logic          accept;
	logic          in_range;

	// Size zero behaves as one, anything above the maximum as the maximum.
	always_comb begin
		if (matrix_size == '0) begin
			n_eff = CW'(1);
		end else if (int'(matrix_size) > MAX_DIM) begin
			n_eff = CW'(MAX_DIM);
		end else begin
			n_eff = CW'(matrix_size);
		end
		n_m1 = n_eff - CW'(1);
	end

	assign item_ready = (state_q == ST_IDLE);
	assign accept     = item_valid && item_ready;
	assign in_range   = (int'(item_row) < MAX_DIM) && (int'(item_col) < MAX_DIM);

	assign wr_addr   = AW'(int'(item_row) * MAX_DIM + int'(item_col));
	assign rd_a_addr = AW'(int'(r_q) * MAX_DIM + int'(i_q));
	assign rd_b_addr = AW'(int'(i_q) * MAX_DIM + int'(c_q));

	always_comb begin
		cmd           = '0;
		cmd.wr_en     = accept && !item_compute && in_range;
		cmd.wr_second = item_second;
		cmd.out_row   = IDX_W'(r_q);
		cmd.out_col   = IDX_W'(c_q);
		cmd.out_last  = (r_q == n_m1) && (c_q == n_m1);
		cmd.first     = (i_q == '0);
		cmd.last      = (i_q == n_m1);
		cmd.rd_en     = (state_q == ST_ISSUE);
		cmd.load_out  = (state_q == ST_WAIT) && status.acc_valid && status.out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			r_q     <= '0;
			c_q     <= '0;
			i_q     <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept && item_compute) begin
						r_q     <= '0;
						c_q     <= '0;
						i_q     <= '0;
						state_q <= ST_ISSUE;
					end
				end
				ST_ISSUE: begin
					if (i_q == n_m1) begin
						i_q     <= '0;
						state_q <= ST_WAIT;
					end else begin
						i_q <= i_q + CW'(1);
					end
				end
				ST_WAIT: begin
					if (cmd.load_out) begin
						if (c_q == n_m1) begin
							c_q <= '0;
							if (r_q == n_m1) begin
								state_q <= ST_IDLE;
							end else begin
								r_q     <= r_q + CW'(1);
								state_q <= ST_ISSUE;
							end
						end else begin
							c_q     <= c_q + CW'(1);
							state_q <= ST_ISSUE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end
endmodule

FILE: src/smm_datapath.sv
module smm_datapath #(
	parameter int MAX_DIM = 8
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  smm_pkg::cmd_t                       cmd,
	input  logic [((MAX_DIM * MAX_DIM > 1) ? $clog2(MAX_DIM * MAX_DIM) : 1)-1:0] wr_addr,
	input  logic [((MAX_DIM * MAX_DIM > 1) ? $clog2(MAX_DIM * MAX_DIM) : 1)-1:0] rd_a_addr,
	input  logic [((MAX_DIM * MAX_DIM > 1) ? $clog2(MAX_DIM * MAX_DIM) : 1)-1:0] rd_b_addr,
	input  logic [smm_pkg::VALUE_W-1:0]         wr_data,
	output smm_pkg::status_t                    status,
	smm_result_if.source                        results
);
	import smm_pkg::*;

	localparam int DEPTH = MAX_DIM * MAX_DIM;

	logic [VALUE_W-1:0] a_rd_s1;
	logic [VALUE_W-1:0] b_rd_s1;
	logic               vld_s1;
	logic               first_s1;
	logic               last_s1;
	logic [VALUE_W-1:0] prod_s2;
	logic               vld_s2;
	logic               first_s2;
	logic               last_s2;
	logic [VALUE_W-1:0] acc_q;
	logic               acc_valid_q;
	logic               out_valid_q;
	logic [VALUE_W-1:0] out_value_q;
	logic [IDX_W-1:0]   out_row_q;
	logic [IDX_W-1:0]   out_col_q;
	logic               out_last_q;

	smm_ram #(.WIDTH(VALUE_W), .DEPTH(DEPTH)) u_first_ram (
		.clk     (clk),
		.wr_en   (cmd.wr_en && !cmd.wr_second),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (cmd.rd_en),
		.rd_addr (rd_a_addr),
		.rd_data (a_rd_s1)
	);

	smm_ram #(.WIDTH(VALUE_W), .DEPTH(DEPTH)) u_second_ram (
		.clk     (clk),
		.wr_en   (cmd.wr_en && cmd.wr_second),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (cmd.rd_en),
		.rd_addr (rd_b_addr),
		.rd_data (b_rd_s1)
	);

	// Tags follow the read data through the multiply and accumulate stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1      <= 1'b0;
			first_s1    <= 1'b0;
			last_s1     <= 1'b0;
			vld_s2      <= 1'b0;
			first_s2    <= 1'b0;
			last_s2     <= 1'b0;
			acc_valid_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			vld_s1   <= cmd.rd_en;
			first_s1 <= cmd.first;
			last_s1  <= cmd.last;
			vld_s2   <= vld_s1;
			first_s2 <= first_s1;
			last_s2  <= last_s1;
			if (vld_s2 && last_s2) begin
				acc_valid_q <= 1'b1;
			end else if (cmd.load_out) begin
				acc_valid_q <= 1'b0;
			end
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (results.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Only the low word of each product is kept, so sign does not matter.
	always_ff @(posedge clk) begin
		prod_s2 <= a_rd_s1 * b_rd_s1;
		if (vld_s2) begin
			acc_q <= first_s2 ? prod_s2 : acc_q + prod_s2;
		end
		if (cmd.load_out) begin
			out_value_q <= acc_q;
			out_row_q   <= cmd.out_row;
			out_col_q   <= cmd.out_col;
			out_last_q  <= cmd.out_last;
		end
	end

	assign status.acc_valid = acc_valid_q;
	assign status.out_free  = !out_valid_q || results.ready;

	assign results.valid         = out_valid_q;
	assign results.product_value = out_value_q;
	assign results.out_row       = out_row_q;
	assign results.out_col       = out_col_q;
	assign results.last_element  = out_last_q;
endmodule

FILE: test/smm_checker.sv
module smm_checker #(
	parameter int MAX_DIM = 8
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic                          pready,
	input  logic [smm_pkg::PADDR_W-1:0]   paddr,
	input  logic [smm_pkg::PDATA_W-1:0]   pwdata,
	smm_item_if                           items,
	smm_result_if                         results,
	output int unsigned                   failures,
	output int unsigned                   pending,
	output int unsigned                   words_checked
);
	import smm_pkg::*;

	typedef struct packed {
		logic [VALUE_W-1:0] value;
		logic [IDX_W-1:0]   row;
		logic [IDX_W-1:0]   col;
		logic               last;
	} product_word_t;

	logic [VALUE_W-1:0] first_m  [MAX_DIM][MAX_DIM];
	logic [VALUE_W-1:0] second_m [MAX_DIM][MAX_DIM];
	logic [SIZE_W-1:0]  matrix_size = SIZE_RESET;
	product_word_t      expected_products [$];
	product_word_t      wanted;
	product_word_t      seen;

	initial begin
		failures      = 0;
		pending       = 0;
		words_checked = 0;
	end

	// A size of zero behaves as one; anything above the array bound is clamped to it.
	function automatic int unsigned dim_in_use(input logic [SIZE_W-1:0] code);
		if (code == 0)
			return 1;
		if (code > MAX_DIM)
			return MAX_DIM;
		return code;
	endfunction

	// Dot product of a row of the first matrix with a column of the second,
	// wrapping at 32 bits as the hardware does.
	function automatic logic [VALUE_W-1:0] dot_product(input int unsigned r, c, n);
		logic [VALUE_W-1:0] acc;
		acc = '0;
		for (int unsigned i = 0; i < n; i++)
			acc = acc + first_m[r][i] * second_m[i][c];
		return acc;
	endfunction

	function automatic void predict_product_matrix();
		int unsigned   n;
		product_word_t w;
		n = dim_in_use(matrix_size);
		for (int unsigned r = 0; r < n; r++) begin
			for (int unsigned c = 0; c < n; c++) begin
				w.value = dot_product(r, c, n);
				w.row   = IDX_W'(r);
				w.col   = IDX_W'(c);
				w.last  = (r == n - 1) && (c == n - 1);
				expected_products = {expected_products, w};
			end
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			matrix_size = SIZE_RESET;
			expected_products.delete();
		end else begin
			if (psel && penable && pwrite && pready && paddr[2] == REG_MATRIX_SIZE)
				matrix_size = pwdata[SIZE_W-1:0];

			if (results.valid && results.ready) begin
				seen = '{results.product_value, results.out_row, results.out_col,
					results.last_element};
				if (expected_products.size() == 0) begin
					failures++;
					$display("%0t: unexpected product word: value %0d row %0d col %0d last %0b",
						$time, $signed(seen.value), seen.row, seen.col, seen.last);
				end else begin
					wanted = expected_products.pop_front();
					words_checked++;
					if (seen !== wanted) begin
						failures++;
						$display({"%0t: product mismatch: expected value %0d row %0d col %0d",
							" last %0b, got value %0d row %0d col %0d last %0b"},
							$time, $signed(wanted.value), wanted.row, wanted.col,
							wanted.last, $signed(seen.value), seen.row, seen.col,
							seen.last);
					end
				end
			end

			if (items.valid && items.ready) begin
				if (items.compute)
					predict_product_matrix();
				else if (items.load_second)
					second_m[items.row_index][items.col_index] = items.element_value;
				else
					first_m[items.row_index][items.col_index] = items.element_value;
			end
		end
		pending <= expected_products.size();
	end

endmodule

FILE: test/tb.sv
module tb;
	import smm_pkg::*;

	localparam int          MAX_DIM     = 8;
	// Stimulus stops once this many item words have been accepted; the last
	// stretch, from CALM_FROM on, runs with no idling on either side.
	localparam int unsigned ITEM_TARGET = 500;
	localparam int unsigned CALM_FROM   = 430;
	// Cycles allowed after the last expected word before the verdict, and
	// before any register write, so that a trailing load has settled.
	localparam int unsigned SETTLE      = 16;
	// The slowest legal run is roughly every word a full 8x8 multiply with
	// the longest stall burst on every product word; this is several times that.
	localparam int unsigned CYCLE_LIMIT = 3_000_000;

	// Item word encodings.
	localparam logic OP_LOAD       = 1'b0;
	localparam logic OP_MULTIPLY   = 1'b1;
	localparam logic MATRIX_FIRST  = 1'b0;
	localparam logic MATRIX_SECOND = 1'b1;

	localparam logic [VALUE_W-1:0] VALUE_MIN      = 32'h8000_0000;
	localparam logic [VALUE_W-1:0] VALUE_MAX      = 32'h7fff_ffff;
	localparam logic [VALUE_W-1:0] VALUE_ALL_ONES = 32'hffff_ffff;

	logic                clk;
	logic                arst_n;
	logic                psel;
	logic                penable;
	logic                pwrite;
	logic [PADDR_W-1:0]  paddr;
	logic [PDATA_W-1:0]  pwdata;
	logic [PDATA_W-1:0]  prdata;
	logic                pready;

	smm_item_if   item_bus ();
	smm_result_if product_bus ();

	int unsigned failures;
	int unsigned pending;
	int unsigned words_checked;

	int unsigned loads      = 0;
	int unsigned multiplies = 0;
	int unsigned cycles     = 0;
	bit [15:0]   sizes_used = '0;
	logic        calm;

	// Cells already loaded, so that a multiply never reads a cell that was
	// never written.
	bit first_set  [MAX_DIM][MAX_DIM];
	bit second_set [MAX_DIM][MAX_DIM];

	// Receiver stall state: a burst level and the cycles left in it.
	int unsigned ready_left  = 0;
	logic        ready_level = 1'b1;

	assign calm = (loads + multiplies) >= CALM_FROM;

	square_matrix_multiply #(
		.MAX_DIM (MAX_DIM)
	) u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.items   (item_bus),
		.results (product_bus)
	);

	smm_checker #(
		.MAX_DIM (MAX_DIM)
	) u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.pready        (pready),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.items         (item_bus),
		.results       (product_bus),
		.failures      (failures),
		.pending       (pending),
		.words_checked (words_checked)
	);

	always #4 clk = ~clk;

	// The cycle counter doubles as the watchdog: a hung handshake or a lost
	// product word ends the run here.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("%0t: timed out with %0d product words outstanding", $time, pending);
			$display("square_matrix_multiply test failed");
			$finish;
		end
	end

	// The result side alternates random ready bursts with random stall
	// bursts, so stalls land on every stage of a multiply.
	// Once the run is in its calm stretch, ready is simply held high.
	always @(posedge clk) begin
		if (ready_left == 0) begin
			ready_level = !ready_level;
			ready_left  = ready_level ? $urandom_range(1, 40) : $urandom_range(1, 13);
		end
		ready_left--;
		product_bus.ready <= calm || ready_level;
	end

	// Element values favour the corners of the signed range and small values
	// of either sign, so that wrap-around in both products and sums is hit.
	function automatic logic [VALUE_W-1:0] pick_value();
		case ($urandom_range(0, 9))
			0:       return VALUE_MIN;
			1:       return VALUE_MAX;
			2:       return VALUE_ALL_ONES;
			3:       return '0;
			4, 5:    return VALUE_W'($urandom_range(0, 32)) - VALUE_W'(16);
			default: return $urandom();
		endcase
	endfunction

	// Most phases use small sizes to keep the run short; a few use the full
	// size, and now and then a code outside the nominal range is used.
	function automatic logic [SIZE_W-1:0] pick_size_code();
		case ($urandom_range(0, 19))
			0:          return '0;
			1:          return SIZE_W'($urandom_range(MAX_DIM + 1, 15));
			2, 3:       return SIZE_W'(MAX_DIM);
			4, 5, 6:    return SIZE_W'($urandom_range(5, MAX_DIM - 1));
			default:    return SIZE_W'($urandom_range(1, 4));
		endcase
	endfunction

	function automatic int unsigned dim_for(input logic [SIZE_W-1:0] code);
		if (code == 0)
			return 1;
		return (code > MAX_DIM) ? MAX_DIM : code;
	endfunction

	// Presents one item word and returns at the edge where it is accepted.
	// valid is left high, so the caller either presents the next word in the
	// same step or lowers valid; a random gap may first drop valid.
	task automatic send_word(input logic op, input logic sel, input logic [IDX_W-1:0] row,
		input logic [IDX_W-1:0] col, input logic [VALUE_W-1:0] value);
		int unsigned gap;
		gap = 0;
		if (!calm && $urandom_range(0, 3) == 0)
			gap = $urandom_range(1, 13);
		if (gap != 0) begin
			item_bus.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_bus.valid         <= 1'b1;
		item_bus.compute       <= op;
		item_bus.load_second   <= sel;
		item_bus.row_index     <= row;
		item_bus.col_index     <= col;
		item_bus.element_value <= value;
		do @(posedge clk); while (item_bus.ready !== 1'b1);
		if (op == OP_MULTIPLY)
			multiplies++;
		else
			loads++;
	endtask

	task automatic load_cell(input logic sel, input int unsigned row, input int unsigned col,
		input logic [VALUE_W-1:0] value);
		send_word(OP_LOAD, sel, IDX_W'(row), IDX_W'(col), value);
		if (sel == MATRIX_SECOND)
			second_set[row][col] = 1'b1;
		else
			first_set[row][col] = 1'b1;
	endtask

	// The fields other than the operation are ignored on a multiply, so
	// they carry random bits.
	task automatic multiply();
		send_word(OP_MULTIPLY, 1'($urandom()), IDX_W'($urandom()), IDX_W'($urandom()),
			$urandom());
	endtask

	// Loads whatever cells of the active n by n corner are still unwritten,
	// in both matrices.
	task automatic fill_corner(input int unsigned n);
		for (int unsigned r = 0; r < n; r++) begin
			for (int unsigned c = 0; c < n; c++) begin
				if (!first_set[r][c])
					load_cell(MATRIX_FIRST, r, c, pick_value());
				if (!second_set[r][c])
					load_cell(MATRIX_SECOND, r, c, pick_value());
			end
		end
	endtask

	// Waits until every expected product word has come back, then a little
	// longer so that a final load has also been written.
	task automatic wait_idle();
		item_bus.valid <= 1'b0;
		@(posedge clk);
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// Writes the size register over the APB port, only once the block is
	// idle. Bits above the register width carry random values.
	task automatic set_size(input logic [SIZE_W-1:0] code);
		wait_idle();
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= PADDR_W'({REG_MATRIX_SIZE, 2'b00});
		pwdata  <= {(PDATA_W - SIZE_W)'($urandom()), code};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
		sizes_used[code] = 1'b1;
	endtask

	initial begin
		int unsigned        phase;
		int unsigned        n;
		logic [SIZE_W-1:0]  code;

		clk                       = 1'b0;
		arst_n                    = 1'b0;
		psel                      = 1'b0;
		penable                   = 1'b0;
		pwrite                    = 1'b0;
		paddr                     = '0;
		pwdata                    = '0;
		item_bus.valid            = 1'b0;
		item_bus.compute          = OP_LOAD;
		item_bus.load_second      = MATRIX_FIRST;
		item_bus.row_index        = '0;
		item_bus.col_index        = '0;
		item_bus.element_value    = '0;
		product_bus.ready         = 1'b0;

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part. A one by one product of the most negative value and
		// minus one, which wraps back to the most negative value; the
		// multiply word carries all ones in its unused fields.
		set_size(SIZE_W'(1));
		load_cell(MATRIX_FIRST, 0, 0, VALUE_MIN);
		load_cell(MATRIX_SECOND, 0, 0, VALUE_ALL_ONES);
		send_word(OP_MULTIPLY, MATRIX_SECOND, '1, '1, VALUE_ALL_ONES);

		// A size of zero, which must behave as one, with the largest
		// positive value squared; unused fields are all zeros this time.
		set_size('0);
		load_cell(MATRIX_FIRST, 0, 0, VALUE_MAX);
		load_cell(MATRIX_SECOND, 0, 0, VALUE_MAX);
		send_word(OP_MULTIPLY, MATRIX_FIRST, '0, '0, '0);

		// Two by two with the range corners, so that sums overflow as well.
		set_size(SIZE_W'(2));
		load_cell(MATRIX_FIRST, 0, 1, VALUE_MIN);
		load_cell(MATRIX_FIRST, 1, 0, VALUE_MAX);
		load_cell(MATRIX_FIRST, 1, 1, VALUE_ALL_ONES);
		load_cell(MATRIX_SECOND, 0, 1, VALUE_MAX);
		load_cell(MATRIX_SECOND, 1, 0, VALUE_MIN);
		load_cell(MATRIX_SECOND, 1, 1, '0);
		multiply();

		// Random phases. Each writes a size, scatters loads over the whole
		// array (cells beyond the active corner stay stored for later, larger
		// sizes), fills any gap in the active corner and multiplies. The
		// first phases force the largest code, the full size and the lowest
		// code above the bound.
		phase = 0;
		while (loads + multiplies < ITEM_TARGET) begin
			case (phase)
				0:       code = '1;
				1:       code = SIZE_W'(MAX_DIM);
				2:       code = SIZE_W'(MAX_DIM + 1);
				default: code = pick_size_code();
			endcase
			set_size(code);
			n = dim_for(code);
			repeat ($urandom_range(1, 3)) begin
				repeat ($urandom_range(0, 8))
					load_cell(1'($urandom()), $urandom_range(0, MAX_DIM - 1),
						$urandom_range(0, MAX_DIM - 1), pick_value());
				fill_corner(n);
				multiply();
			end
			phase++;
		end

		wait_idle();

		$display({"Covered %0d load words and %0d multiply words over %0d size",
			" settings (codes used %04h)."}, loads, multiplies, phase + 3, sizes_used);
		$display("Checked %0d product words against the predicted product matrices.",
			words_checked);
		if (failures == 0 && pending == 0) begin
			$display("square_matrix_multiply test passed");
		end else begin
			$display("square_matrix_multiply test failed");
		end
		$finish;
	end

endmodule
